// ===== hdl/hng_pkg.sv =====
// ----------------------------------------------------------------------------
// hng_pkg
// shared types, constants and helpers of the heightfield normal generator
// ----------------------------------------------------------------------------
package hng_pkg;

	// grid geometry
	localparam int MAX_GRID = 256;
	localparam int COL_W    = $clog2(MAX_GRID);
	localparam int CNT_W    = $clog2(MAX_GRID + 1);
	localparam int ADDR_W   = COL_W + 1;
	localparam int DEPTH    = 2 * MAX_GRID;

	// payload widths
	localparam int POS_W  = 8;
	localparam int Z_W    = 20;
	localparam int H_W    = 17;
	localparam int Q_W    = 16;
	localparam int UQ_W   = 15;
	localparam int CFG_W  = 32;
	localparam int PADDR_W = 4;

	// arithmetic widths
	localparam int ZX_W   = 23;
	localparam int MAG_W  = 38;
	localparam int G_W    = MAG_W + 1;
	localparam int NORM_W = 30;
	localparam int SQ_W   = 62;
	localparam int RT_W   = 63;
	localparam int R_W    = 32;
	localparam int FRAC_W = 14;

	localparam logic signed [ZX_W-1:0] Z_FALLBACK = -23'sd4800;
	localparam logic [MAG_W-1:0]       GRAD_ONE   = MAG_W'(1) << 21;

	localparam int FIFO_DEPTH = 4;

	// register map indexes
	localparam logic [1:0] REG_GRID_N  = 2'd0;
	localparam logic [1:0] REG_SPACING = 2'd1;
	localparam logic [1:0] REG_SINK    = 2'd2;

	typedef struct packed {
		logic [COL_W-1:0]    col;
		logic [COL_W-1:0]    row;
		logic signed [Z_W-1:0] zc;
		logic signed [Z_W-1:0] zl;
		logic signed [Z_W-1:0] zr;
		logic signed [Z_W-1:0] zd;
		logic signed [Z_W-1:0] zu;
		logic                spx2;
		logic                spy2;
		logic                done;
		logic                last;
	} hng_job_t;

	// grid size clamped to the supported range
	function automatic logic [CNT_W-1:0] eff_n(input logic [8:0] g);
		logic [CNT_W-1:0] n;
		if (int'(g) < 2) n = CNT_W'(2);
		else if (int'(g) > MAX_GRID) n = CNT_W'(MAX_GRID);
		else n = CNT_W'(g);
		return n;
	endfunction

endpackage

// ===== hdl/hng_ram.sv =====
// ----------------------------------------------------------------------------
// hng_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hng_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/hng_fifo.sv =====
// ----------------------------------------------------------------------------
// hng_fifo
// short job queue between the front sequencer and the normal engine
// ----------------------------------------------------------------------------
module hng_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hng_pkg::hng_job_t din,
	output logic              full,
	input  logic              pop,
	output hng_pkg::hng_job_t dout,
	output logic              empty
);
	import hng_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_FW = $clog2(FIFO_DEPTH + 1);

	hng_job_t          buf_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_FW-1:0] cnt_q;

	assign full  = cnt_q == CNT_FW'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== hdl/hng_front.sv =====
// ----------------------------------------------------------------------------
// hng_front
// accepts samples, keeps the two row store and turns each sample into jobs
// ----------------------------------------------------------------------------
module hng_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [hng_pkg::H_W-1:0]  bed_height,
	input  logic                            sample_valid,
	input  logic [8:0]                      grid_n,
	input  logic [15:0]                     bed_sink,
	input  logic                            restart,
	output hng_pkg::hng_job_t               job,
	output logic                            job_push,
	input  logic                            job_full
);
	import hng_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_READ = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]            state_q;
	logic [2:0]            st_q;
	logic [1:0]            ji_q;
	logic [COL_W-1:0]      colc_q, rowc_q, x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic signed [Z_W-1:0] rd_q [7];

	logic [CNT_W-1:0]      n;
	logic                  accept, wrap;
	logic [COL_W-1:0]      xa, ya;
	logic signed [ZX_W-1:0] h25, zx;
	logic [CNT_W-1:0]      xn, yn;
	logic [COL_W-1:0]      xl, xr, c, xl2;
	logic                  cur_b, own_b;
	logic [ADDR_W-1:0]     raddr;
	logic [Z_W-1:0]        rdata;
	logic                  last_row, p0, p1, p2, pres, advance;
	hng_job_t              j0, j1, j2;

	assign n        = eff_n(grid_n);
	assign in_ready = state_q == F_IDLE;
	assign accept   = in_valid && in_ready;

	// position of the incoming sample
	assign wrap = CNT_W'(colc_q) >= n || CNT_W'(rowc_q) >= n;
	assign xa   = wrap ? '0 : colc_q;
	assign ya   = wrap ? '0 : rowc_q;
	assign xn   = CNT_W'(xa) + 1'b1;
	assign yn   = CNT_W'(ya) + 1'b1;

	// vertex height, rounding half up on the quarter
	always_comb begin
		h25 = ZX_W'(bed_height) * 23'sd25;
		if (sample_valid) zx = ((h25 + 23'sd2) >>> 2) - $signed(ZX_W'(bed_sink));
		else zx = Z_FALLBACK - $signed(ZX_W'(bed_sink));
	end

	// neighbor columns
	assign xl    = (x_q == '0) ? '0 : x_q - 1'b1;
	assign xr    = (CNT_W'(x_q) + 1'b1 < n) ? x_q + 1'b1 : COL_W'(n - 1'b1);
	assign c     = x_q - 1'b1;
	assign xl2   = (c == '0) ? '0 : c - 1'b1;
	assign cur_b = ~y_q[0];
	assign own_b = y_q[0];

	always_comb begin
		unique case (st_q)
			3'd0: raddr = {cur_b, xl};
			3'd1: raddr = {cur_b, x_q};
			3'd2: raddr = {cur_b, xr};
			3'd3: raddr = {own_b, x_q};
			3'd4: raddr = {own_b, c};
			3'd5: raddr = {own_b, xl2};
			3'd6: raddr = {cur_b, c};
			default: raddr = {own_b, x_q};
		endcase
	end

	hng_ram #(.WIDTH(Z_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (state_q == F_READ && st_q == 3'd7),
		.waddr ({own_b, x_q}),
		.wdata (z_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// jobs of this sample
	assign last_row = CNT_W'(y_q) == n - 1'b1;
	assign p0 = y_q != '0;
	assign p1 = last_row && x_q != '0;
	assign p2 = last_row && CNT_W'(x_q) == n - 1'b1;

	always_comb begin
		j0.col  = x_q;
		j0.row  = y_q - 1'b1;
		j0.zc   = rd_q[1];
		j0.zl   = rd_q[0];
		j0.zr   = rd_q[2];
		j0.zd   = (y_q == COL_W'(1)) ? rd_q[1] : rd_q[3];
		j0.zu   = z_q;
		j0.spx2 = x_q == '0 || CNT_W'(x_q) == n - 1'b1;
		j0.spy2 = y_q == COL_W'(1);
		j0.done = 1'b0;
		j0.last = !p1 && !p2;

		j1.col  = c;
		j1.row  = y_q;
		j1.zc   = rd_q[4];
		j1.zl   = rd_q[5];
		j1.zr   = z_q;
		j1.zd   = rd_q[6];
		j1.zu   = rd_q[4];
		j1.spx2 = x_q == COL_W'(1);
		j1.spy2 = 1'b1;
		j1.done = 1'b0;
		j1.last = !p2;

		j2.col  = x_q;
		j2.row  = y_q;
		j2.zc   = z_q;
		j2.zl   = rd_q[4];
		j2.zr   = z_q;
		j2.zd   = rd_q[1];
		j2.zu   = z_q;
		j2.spx2 = 1'b1;
		j2.spy2 = 1'b1;
		j2.done = 1'b1;
		j2.last = 1'b1;
	end

	always_comb begin
		unique case (ji_q)
			2'd0: begin
				job  = j0;
				pres = p0;
			end
			2'd1: begin
				job  = j1;
				pres = p1;
			end
			default: begin
				job  = j2;
				pres = p2;
			end
		endcase
	end

	assign job_push = state_q == F_PUSH && pres && !job_full;
	assign advance  = !pres || !job_full;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= xa;
			y_q <= ya;
			z_q <= zx[Z_W-1:0];
		end
		if (state_q == F_READ && st_q != 3'd0) begin
			rd_q[st_q - 1'b1] <= $signed(rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			st_q    <= '0;
			ji_q    <= '0;
			colc_q  <= '0;
			rowc_q  <= '0;
		end else begin
			if (restart) begin
				colc_q <= '0;
				rowc_q <= '0;
			end else if (accept) begin
				if (xn == n) begin
					colc_q <= '0;
					rowc_q <= (yn == n) ? '0 : yn[COL_W-1:0];
				end else begin
					colc_q <= xn[COL_W-1:0];
					rowc_q <= ya;
				end
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_READ;
						st_q    <= '0;
					end
				end
				F_READ: begin
					st_q <= st_q + 1'b1;
					if (st_q == 3'd7) begin
						state_q <= F_PUSH;
						ji_q    <= '0;
					end
				end
				F_PUSH: begin
					if (advance) begin
						if (ji_q == 2'd2) state_q <= F_IDLE;
						else ji_q <= ji_q + 1'b1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/hng_back.sv =====
// ----------------------------------------------------------------------------
// hng_back
// gradient, shared square root and divider, normal and tangent per job
// ----------------------------------------------------------------------------
module hng_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hng_pkg::hng_job_t               job,
	input  logic                            job_empty,
	output logic                            job_pop,
	input  logic [15:0]                     spacing_recip,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hng_pkg::POS_W-1:0]       col,
	output logic [hng_pkg::POS_W-1:0]       row,
	output logic signed [hng_pkg::Z_W-1:0]  vertex_z,
	output logic signed [hng_pkg::Q_W-1:0]  normal_x,
	output logic signed [hng_pkg::Q_W-1:0]  normal_y,
	output logic [hng_pkg::UQ_W-1:0]        normal_z,
	output logic [hng_pkg::UQ_W-1:0]        tangent_x,
	output logic signed [hng_pkg::Q_W-1:0]  tangent_z,
	output logic                            last_of_run,
	output logic                            grid_done
);
	import hng_pkg::*;

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_GX   = 4'd1;
	localparam logic [3:0] B_GY   = 4'd2;
	localparam logic [3:0] B_MAG  = 4'd3;
	localparam logic [3:0] B_SQ   = 4'd4;
	localparam logic [3:0] B_SQRT = 4'd5;
	localparam logic [3:0] B_DIVI = 4'd6;
	localparam logic [3:0] B_DIVS = 4'd7;
	localparam logic [3:0] B_OUT  = 4'd8;

	logic [3:0]              state_q;
	hng_job_t                job_q;
	logic signed [G_W-1:0]   gx_q, gy_q;
	logic                    vsel_q;
	logic [NORM_W-1:0]       m_q [3];
	logic                    neg_q [3];
	logic [4:0]              k_q;
	logic [1:0]              ci_q;
	logic [SQ_W-1:0]         acc_q;
	logic [RT_W-1:0]         v_q, res_q;
	logic [R_W-1:0]          r_q, rem_q;
	logic [UQ_W-1:0]         quo_q, low_q;
	logic signed [Q_W-1:0]   nrm_q [3];
	logic signed [Q_W-1:0]   tx_q, tz_q;

	logic signed [Z_W:0]     diff;
	logic signed [G_W-2:0]   prod;
	logic signed [G_W-1:0]   gval;
	logic [MAG_W-1:0]        mag [3];
	logic                    neg [3];
	logic [MAG_W-1:0]        big;
	logic [3:0]              sh;
	logic [2*NORM_W-1:0]     sq;
	logic [SQ_W-1:0]         acc_n;
	logic [RT_W-1:0]         bsel, trial_r;
	logic [NORM_W+FRAC_W:0]  dvd;
	logic [R_W:0]            trial;
	logic                    qb;
	logic [UQ_W-1:0]         qn;
	logic signed [Q_W-1:0]   qs;
	logic                    load_out;

	function automatic logic [MAG_W-1:0] absg(input logic signed [G_W-1:0] g);
		logic signed [G_W-1:0] a;
		a = (g < 0) ? -g : g;
		return a[MAG_W-1:0];
	endfunction

	assign job_pop = state_q == B_IDLE && !job_empty;

	// one gradient product per cycle
	always_comb begin
		if (state_q == B_GX) diff = (Z_W+1)'(job_q.zr) - (Z_W+1)'(job_q.zl);
		else diff = (Z_W+1)'(job_q.zu) - (Z_W+1)'(job_q.zd);
		prod = (G_W-1)'(diff) * (G_W-1)'($signed({1'b0, spacing_recip}));
		if ((state_q == B_GX) ? job_q.spx2 : job_q.spy2) gval = G_W'(prod) <<< 1;
		else gval = G_W'(prod);
	end

	// component magnitudes of the vector in work and its pre-shift
	always_comb begin
		if (!vsel_q) begin
			mag[0] = absg(gx_q);
			mag[1] = absg(gy_q);
			mag[2] = GRAD_ONE;
			neg[0] = gx_q > 0;
			neg[1] = gy_q > 0;
			neg[2] = 1'b0;
		end else begin
			mag[0] = GRAD_ONE;
			mag[1] = '0;
			mag[2] = absg(gx_q);
			neg[0] = 1'b0;
			neg[1] = 1'b0;
			neg[2] = gx_q < 0;
		end
		big = mag[0];
		if (mag[1] > big) big = mag[1];
		if (mag[2] > big) big = mag[2];
		sh = '0;
		for (int i = 0; i < MAG_W - NORM_W; i++) begin
			if (big[NORM_W + i]) sh = 4'(i + 1);
		end
	end

	assign sq    = m_q[k_q[1:0]] * m_q[k_q[1:0]];
	assign acc_n = ((k_q == '0) ? '0 : acc_q) + SQ_W'(sq);

	// one root bit per cycle
	assign bsel    = RT_W'(1) << {k_q, 1'b0};
	assign trial_r = res_q + bsel;

	// one quotient bit per cycle
	assign dvd   = {m_q[ci_q], FRAC_W'(0)} + (NORM_W+FRAC_W+1)'(r_q >> 1);
	assign trial = {rem_q, low_q[k_q[3:0]]};
	assign qb    = trial >= {1'b0, r_q} && r_q != '0;
	assign qn    = {quo_q[UQ_W-2:0], qb};
	assign qs    = neg_q[ci_q] ? -$signed(Q_W'(qn)) : $signed(Q_W'(qn));

	assign load_out = state_q == B_OUT && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!job_empty) job_q <= job;
			end
			B_GX: gx_q <= gval;
			B_GY: gy_q <= gval;
			B_MAG: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= NORM_W'(mag[i] >> sh);
					neg_q[i] <= neg[i];
				end
			end
			B_SQ: begin
				acc_q <= acc_n;
				if (k_q == 5'd2) begin
					v_q   <= RT_W'(acc_n);
					res_q <= '0;
				end
			end
			B_SQRT: begin
				if (v_q >= trial_r) begin
					v_q   <= v_q - trial_r;
					res_q <= (res_q >> 1) + bsel;
				end else begin
					res_q <= res_q >> 1;
				end
				if (k_q == '0) begin
					if (v_q >= trial_r) r_q <= R_W'((res_q >> 1) + bsel);
					else r_q <= R_W'(res_q >> 1);
				end
			end
			B_DIVI: begin
				rem_q <= R_W'(dvd >> UQ_W);
				low_q <= dvd[UQ_W-1:0];
				quo_q <= '0;
			end
			B_DIVS: begin
				quo_q <= qn;
				if (qb) rem_q <= R_W'(trial - {1'b0, r_q});
				else rem_q <= R_W'(trial);
				if (k_q == '0) begin
					if (!vsel_q) nrm_q[ci_q] <= qs;
					else if (ci_q == '0) tx_q <= qs;
					else tz_q <= qs;
				end
			end
			default: ;
		endcase
		if (load_out) begin
			col         <= POS_W'(job_q.col);
			row         <= POS_W'(job_q.row);
			vertex_z    <= job_q.zc;
			normal_x    <= nrm_q[0];
			normal_y    <= nrm_q[1];
			normal_z    <= nrm_q[2][UQ_W-1:0];
			tangent_x   <= tx_q[UQ_W-1:0];
			tangent_z   <= tz_q;
			last_of_run <= job_q.last;
			grid_done   <= job_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			out_valid <= 1'b0;
			vsel_q    <= 1'b0;
			k_q       <= '0;
			ci_q      <= '0;
		end else begin
			if (load_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				B_IDLE: if (!job_empty) state_q <= B_GX;
				B_GX: state_q <= B_GY;
				B_GY: begin
					state_q <= B_MAG;
					vsel_q  <= 1'b0;
				end
				B_MAG: begin
					state_q <= B_SQ;
					k_q     <= '0;
				end
				B_SQ: begin
					if (k_q == 5'd2) begin
						state_q <= B_SQRT;
						k_q     <= 5'd31;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				B_SQRT: begin
					if (k_q == '0) begin
						state_q <= B_DIVI;
						ci_q    <= '0;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				B_DIVI: begin
					state_q <= B_DIVS;
					k_q     <= 5'(UQ_W - 1);
				end
				B_DIVS: begin
					if (k_q != '0) begin
						k_q <= k_q - 1'b1;
					end else if (ci_q != 2'd2) begin
						state_q <= B_DIVI;
						ci_q    <= (vsel_q && ci_q == '0) ? 2'd2 : ci_q + 1'b1;
					end else if (!vsel_q) begin
						state_q <= B_MAG;
						vsel_q  <= 1'b1;
					end else begin
						state_q <= B_OUT;
					end
				end
				B_OUT: if (load_out) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/heightfield_normal_generator_core.sv =====
// ----------------------------------------------------------------------------
// heightfield_normal_generator_core
// a sample is taken while the front is idle; its 7 store reads and a write follow,
// then its jobs are queued, stalling while the queue is full; no new sample meanwhile
// the back engine works on one job at a time and is paced by its shared
// bit serial square root (32 steps) and divider (16 per component, 5 per result)
// reset: asynchronous, clears counters, queue and handshakes; row store is not cleared
// ----------------------------------------------------------------------------
module heightfield_normal_generator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hng_pkg::PADDR_W-1:0]         paddr,
	input  logic [hng_pkg::CFG_W-1:0]           pwdata,
	output logic [hng_pkg::CFG_W-1:0]           prdata,
	output logic                                pready,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [hng_pkg::H_W-1:0]      bed_height,
	input  logic                                sample_valid,
	// vertex channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hng_pkg::POS_W-1:0]           col,
	output logic [hng_pkg::POS_W-1:0]           row,
	output logic signed [hng_pkg::Z_W-1:0]      vertex_z,
	output logic signed [hng_pkg::Q_W-1:0]      normal_x,
	output logic signed [hng_pkg::Q_W-1:0]      normal_y,
	output logic [hng_pkg::UQ_W-1:0]            normal_z,
	output logic [hng_pkg::UQ_W-1:0]            tangent_x,
	output logic signed [hng_pkg::Q_W-1:0]      tangent_z,
	output logic                                last_of_run,
	output logic                                grid_done
);
	import hng_pkg::*;

	// configuration registers
	logic [8:0]  grid_n_q;
	logic [15:0] spacing_q;
	logic [15:0] sink_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;
	logic        restart;

	// front to queue to back
	hng_job_t    fjob, qjob;
	logic        job_push, job_full, job_pop, job_empty;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];
	// a new grid size starts the grid over at vertex zero
	assign restart = cfg_wr && cfg_idx == REG_GRID_N;

	always_comb begin
		unique case (cfg_idx)
			REG_GRID_N:  prdata = CFG_W'(grid_n_q);
			REG_SPACING: prdata = CFG_W'(spacing_q);
			REG_SINK:    prdata = CFG_W'(sink_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_n_q  <= 9'd64;
			spacing_q <= 16'd655;
			sink_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_GRID_N:  grid_n_q  <= pwdata[8:0];
				REG_SPACING: spacing_q <= pwdata[15:0];
				REG_SINK:    sink_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// front: heights into the two row store, up to three jobs per sample
	hng_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.bed_height   (bed_height),
		.sample_valid (sample_valid),
		.grid_n       (grid_n_q),
		.bed_sink     (sink_q),
		.restart      (restart),
		.job          (fjob),
		.job_push     (job_push),
		.job_full     (job_full)
	);

	// queue lets the front run ahead of the slow normal engine
	hng_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (fjob),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (qjob),
		.empty  (job_empty)
	);

	// back: gradients, normalize, output register with the done flag
	hng_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job            (qjob),
		.job_empty      (job_empty),
		.job_pop        (job_pop),
		.spacing_recip  (spacing_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.col            (col),
		.row            (row),
		.vertex_z       (vertex_z),
		.normal_x       (normal_x),
		.normal_y       (normal_y),
		.normal_z       (normal_z),
		.tangent_x      (tangent_x),
		.tangent_z      (tangent_z),
		.last_of_run    (last_of_run),
		.grid_done      (grid_done)
	);

`ifndef ASSERT_OFF
	// the front never pushes into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full queue");

	// the grid's last vertex ends its sample's run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grid_done |-> last_of_run)
		else $error("grid done without last of run");

	// the last vertex sits on the diagonal
	a_done_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grid_done |-> row == col)
		else $error("grid done off the diagonal");
`endif
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the heightfield normal generator: samples are
// streamed in raster order over valid/ready, every vertex result is predicted
// in the bench and compared field by field, registers are set over apb
// between phases
// ----------------------------------------------------------------------------
module tb_top;
	import hng_pkg::*;

	localparam int  HALF_PERIOD = 10;
	localparam int  CYCLE_LIMIT = 1500000;
	localparam int  SETTLE      = 60;
	localparam int  ROW_OFS     = 256;
	localparam int  RAND_ITEMS  = 111;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic signed [H_W-1:0] height;
		logic                  present;
	} sample_t;

	typedef struct {
		logic [POS_W-1:0]        col;
		logic [POS_W-1:0]        row;
		logic signed [Z_W-1:0]   z;
		logic signed [Q_W-1:0]   nx;
		logic signed [Q_W-1:0]   ny;
		logic [UQ_W-1:0]         nz;
		logic [UQ_W-1:0]         tx;
		logic signed [Q_W-1:0]   tz;
		logic                    last;
		logic                    done;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [CFG_W-1:0]   pwdata = '0;
	logic [CFG_W-1:0]   prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [H_W-1:0] bed_height = '0;
	logic               sample_valid = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [POS_W-1:0]   col, row;
	logic signed [Z_W-1:0] vertex_z;
	logic signed [Q_W-1:0] normal_x, normal_y, tangent_z;
	logic [UQ_W-1:0]    normal_z, tangent_x;
	logic               last_of_run, grid_done;

	// pending samples and vertices still owed by the block
	sample_t sample_q[$];
	vertex_t vertex_q[$];

	// bench copy of the block's registers and state
	logic [8:0]  m_grid = 9'd64;
	logic [15:0] m_recip = 16'd655;
	logic [15:0] m_sink = 16'd0;
	int          height_store[2*ROW_OFS];
	int          cur_col = 0, cur_row = 0;

	int  error_count = 0;
	int  cycle_count = 0;
	int  send_gap = 0, recv_stall = 0;
	bit  send_idle = 1'b0, recv_idle = 1'b0;

	heightfield_normal_generator_core i_dut (.*);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// arithmetic of the vertex path
	// ------------------------------------------------------------------
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned abs64(input longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	// scale a vector to unit length in q2.14
	function automatic void unit_vec(input longint a, input longint b, input longint c,
		output longint oa, output longint ob, output longint oc);
		longint unsigned m[3], big, sum, r, q;
		longint v[3], o[3];
		int sh;
		v[0] = a; v[1] = b; v[2] = c;
		big = 0;
		sum = 0;
		sh = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = abs64(v[i]);
			if (m[i] > big) big = m[i];
		end
		// pre-shift so the squares cannot overflow
		while ((big >> sh) >= (64'd1 << 30)) sh++;
		for (int i = 0; i < 3; i++) begin
			m[i] >>= sh;
			sum += m[i] * m[i];
		end
		r = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (r != 0) ? (m[i] * 16384 + r / 2) / r : 0;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		oa = o[0]; ob = o[1]; oc = o[2];
	endfunction

	function automatic vertex_t shade_vertex(input int x, input int y, input int zc,
		input int zl, input int zr, input int spx, input int zd, input int zu,
		input int spy, input bit done);
		vertex_t v;
		longint gx, gy, n0, n1, n2, t0, t1, t2;
		gx = longint'(zr - zl) * longint'(m_recip) * (spx == 1 ? 2 : 1);
		gy = longint'(zu - zd) * longint'(m_recip) * (spy == 1 ? 2 : 1);
		unit_vec(-gx, -gy, 64'd1 << 21, n0, n1, n2);
		unit_vec(64'd1 << 21, 0, gx, t0, t1, t2);
		v.col  = x[7:0];
		v.row  = y[7:0];
		v.z    = zc[Z_W-1:0];
		v.nx   = n0[Q_W-1:0];
		v.ny   = n1[Q_W-1:0];
		v.nz   = n2[UQ_W-1:0];
		v.tx   = t0[UQ_W-1:0];
		v.tz   = t2[Q_W-1:0];
		v.last = 1'b0;
		v.done = done;
		return v;
	endfunction

	// one accepted sample: store its height, emit the vertices it completes
	task automatic predict_vertices(input logic signed [H_W-1:0] h, input logic present);
		vertex_t got[3];
		int n, x, y, z, yv, xl, xr, c, cur, prv, cnt;
		n = m_grid < 2 ? 2 : (m_grid > MAX_GRID ? MAX_GRID : int'(m_grid));
		x = cur_col;
		y = cur_row;
		cnt = 0;
		if (x >= n || y >= n) begin
			x = 0;
			y = 0;
		end
		// round half up of height * 6.25, then the sink
		if (present) z = int'((longint'(h) * 25 + 2) >>> 2) - int'(m_sink);
		else z = -4800 - int'(m_sink);
		// vertex one row up is now complete
		if (y >= 1) begin
			yv = y - 1;
			cur = (yv & 1) * ROW_OFS;
			xl = x > 0 ? x - 1 : 0;
			xr = x + 1 < n ? x + 1 : n - 1;
			got[cnt++] = shade_vertex(x, yv, height_store[cur + x], height_store[cur + xl],
				height_store[cur + xr], xr - xl,
				yv == 0 ? height_store[cur + x] : height_store[(y & 1) * ROW_OFS + x],
				z, yv == 0 ? 1 : 2, 1'b0);
		end
		height_store[(y & 1) * ROW_OFS + x] = z;
		// last row flushes as it arrives
		if (y == n - 1) begin
			cur = (y & 1) * ROW_OFS;
			prv = ((y - 1) & 1) * ROW_OFS;
			if (x >= 1) begin
				c = x - 1;
				xl = c > 0 ? c - 1 : 0;
				got[cnt++] = shade_vertex(c, y, height_store[cur + c], height_store[cur + xl],
					height_store[cur + x], x - xl, height_store[prv + c],
					height_store[cur + c], 1, 1'b0);
			end
			if (x == n - 1)
				got[cnt++] = shade_vertex(x, y, z, height_store[cur + x - 1], z, 1,
					height_store[prv + x], z, 1, 1'b1);
		end
		x++;
		if (x == n) begin
			x = 0;
			y++;
			if (y == n) y = 0;
		end
		cur_col = x;
		cur_row = y;
		if (cnt > 0) got[cnt - 1].last = 1'b1;
		for (int i = 0; i < cnt; i++) vertex_q.push_back(got[i]);
	endtask

	// ------------------------------------------------------------------
	// sample driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		sample_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) predict_vertices(bed_height, sample_valid);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					s = sample_q.pop_front();
					bed_height   <= s.height;
					sample_valid <= s.present;
					in_valid     <= 1'b1;
					if (send_idle && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// vertex monitor with random back-pressure
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("[%0d] vertex mismatch on %s: got %0d, expected %0d",
			cycle_count, field, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		vertex_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (vertex_q.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					w = vertex_q.pop_front();
					if (col != w.col) report_mismatch("col", col, w.col);
					if (row != w.row) report_mismatch("row", row, w.row);
					if (vertex_z != w.z) report_mismatch("vertex_z", vertex_z, w.z);
					if (normal_x != w.nx) report_mismatch("normal_x", normal_x, w.nx);
					if (normal_y != w.ny) report_mismatch("normal_y", normal_y, w.ny);
					if (normal_z != w.nz) report_mismatch("normal_z", normal_z, w.nz);
					if (tangent_x != w.tx) report_mismatch("tangent_x", tangent_x, w.tx);
					if (tangent_z != w.tz) report_mismatch("tangent_z", tangent_z, w.tz);
					if (last_of_run != w.last) report_mismatch("last_of_run", last_of_run, w.last);
					if (grid_done != w.done) report_mismatch("grid_done", grid_done, w.done);
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (recv_idle && $urandom_range(0, 3) == 0) recv_stall = $urandom_range(1, 3);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// register writes, only while the block is idle
	// ------------------------------------------------------------------
	task automatic apb_write(input logic [1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_GRID_N: begin
				m_grid = value[8:0];
				cur_col = 0;
				cur_row = 0;
			end
			REG_SPACING: m_recip = value[15:0];
			REG_SINK:    m_sink = value[15:0];
			default: ;
		endcase
	endtask

	// block until every owed vertex is out, then let the front end settle
	task automatic drain;
		while (sample_q.size() != 0 || in_valid || vertex_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic push_sample(input logic signed [H_W-1:0] h, input logic present);
		sample_t s;
		s.height = h;
		s.present = present;
		sample_q.push_back(s);
	endtask

	// smooth terrain mostly, with the odd spike and missing sample
	function automatic logic signed [H_W-1:0] rand_height(input logic signed [H_W-1:0] base);
		int d;
		if ($urandom_range(0, 5) == 0) return H_W'($urandom);
		d = int'(base) + $urandom_range(0, 800) - 400;
		if (d > 65535) d = 65535;
		if (d < -65536) d = -65536;
		return H_W'(d);
	endfunction

	initial begin
		int n, fed, cnt;
		logic signed [H_W-1:0] base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// smallest grid via the clamp, extreme recip and sink, height extremes
		apb_write(REG_GRID_N, 32'd1);
		apb_write(REG_SPACING, 32'hFFFF);
		apb_write(REG_SINK, 32'hFFFF);
		push_sample(-17'sd65536, 1'b1);
		push_sample(17'sd65535, 1'b1);
		push_sample(17'sd0, 1'b0);
		push_sample(-17'sd1, 1'b1);
		drain();

		// zero recip gives flat normals; grid_n zero also clamps to two
		apb_write(REG_GRID_N, 32'd0);
		apb_write(REG_SPACING, 32'd0);
		apb_write(REG_SINK, 32'd0);
		push_sample(17'sd100, 1'b1);
		push_sample(-17'sd3000, 1'b1);
		push_sample(17'sd65535, 1'b0);
		push_sample(17'sd2, 1'b1);
		drain();

		// unused register index, then a 3x3 grid with a sharp spike in the middle
		apb_write(REG_UNUSED, 32'hFFFF_FFFF);
		apb_write(REG_GRID_N, 32'd3);
		apb_write(REG_SPACING, 32'd1);
		for (int i = 0; i < 9; i++) push_sample(i == 4 ? 17'sd40000 : H_W'(i * 37 - 150), 1'b1);
		drain();

		// oversized grid_n clamps; the 256 grid is left after two samples for a restart
		apb_write(REG_GRID_N, 32'h1FF);
		apb_write(REG_GRID_N, 32'd256);
		push_sample(17'sd5, 1'b1);
		push_sample(17'sd6, 1'b1);
		drain();

		// random grids, most complete, some cut short by a restart
		fed = 0;
		while (fed < RAND_ITEMS) begin
			n = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(2, 5);
			send_idle = fed < 85 && $urandom_range(0, 3) != 0;
			recv_idle = fed < 85 && $urandom_range(0, 3) != 0;
			apb_write(REG_GRID_N, 32'(n));
			case ($urandom_range(0, 3))
				0: apb_write(REG_SPACING, 32'hFFFF);
				1: apb_write(REG_SPACING, 32'($urandom_range(1, 2000)));
				default: apb_write(REG_SPACING, 32'($urandom_range(0, 65535)));
			endcase
			apb_write(REG_SINK, ($urandom_range(0, 4) == 0) ? 32'hFFFF : 32'($urandom_range(0, 65535)));
			cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n * n - 1) : n * n;
			if (cnt > RAND_ITEMS - fed) cnt = RAND_ITEMS - fed;
			base = H_W'($urandom);
			for (int i = 0; i < cnt; i++) begin
				base = rand_height(base);
				push_sample(base, $urandom_range(0, 7) != 0);
			end
			fed += cnt;
			drain();
		end

		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== heightfield_normal_generator_core.f =====
hdl/hng_pkg.sv
hdl/hng_ram.sv
hdl/hng_fifo.sv
hdl/hng_front.sv
hdl/hng_back.sv
hdl/heightfield_normal_generator_core.sv
bench/tb_top.sv
